/* hw/rtl/bdq_pkg.sv */
// Shared constants, command codes and controller-to-datapath types for the deque.
package bdq_pkg;

  // Storage geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Field widths fixed by the interface
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned CAP_RESET = 16;

  // APB register map
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;
  localparam logic        REG_CAPACITY = 1'b0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  // Steps issued by the controller to the datapath
  typedef struct packed {
    logic load;   // capture command and word
    logic exec;   // update pointers, count and storage
    logic rd;     // read front and rear slots
  } ctrl_cmd_t;

  // (a + b) mod DEPTH for a < DEPTH and b <= DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* hw/rtl/bdq_ctrl.sv */
// Sequencer for one command: capture, execute, read storage, present result.
module bdq_ctrl import bdq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       take;

  // Accept a new command whenever not mid-operation
  assign busy_o = (state_q == ST_EXEC) || (state_q == ST_READ);
  assign take   = start_i && !busy_o;
  assign done_o = (state_q == ST_RESP);

  assign cmd_o.load = take;
  assign cmd_o.exec = (state_q == ST_EXEC);
  assign cmd_o.rd   = (state_q == ST_READ);

  // Advance through the steps of one command
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_READ;
      ST_READ: state_d = ST_RESP;
      ST_RESP: state_d = take ? ST_EXEC : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  // An accepted command always proceeds to execution
  a_take_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> cmd_o.exec)
    else $error("accepted command did not execute");

  // Every executed command is followed by a result, after the storage read step
  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> ##1 done_o)
    else $error("result strobe missing after execution");
`endif

endmodule

/* hw/rtl/bdq_datapath.sv */
// Ring-buffer storage, front pointer, entry count and result registers.
module bdq_datapath import bdq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  input  logic [CMD_W-1:0]         op_i,
  input  logic signed [WORD_W-1:0] push_value_i,
  input  logic [CAP_W-1:0]         capacity_i,
  output logic                     accepted_o,
  output logic signed [WORD_W-1:0] front_word_o,
  output logic signed [WORD_W-1:0] rear_word_o,
  output logic                     is_empty_o,
  output logic                     is_full_o
);

  logic [CMD_W-1:0]  op_q;
  logic [WORD_W-1:0] word_q;
  logic [IDX_W-1:0]  front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ok_q, ok_d;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  rear_idx;
  logic              full_now;
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_front_q, rd_rear_q;

  // Full when count reaches the capacity, saturated at DEPTH
  assign full_now = (32'(count_q) >= 32'(capacity_i)) || (count_q >= CNT_W'(DEPTH));

  // Capture the command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      word_q <= push_value_i;
    end
  end

  // Decide the effect of the command on pointer, count and storage
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    ok_d    = 1'b0;
    we      = 1'b0;
    waddr   = wrap_add(front_q, count_q);
    unique case (op_q)
      CMD_PUSH_FRONT: begin
        if (!full_now) begin
          front_d = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
          waddr   = front_d;
          we      = 1'b1;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (!full_now) begin
          we      = 1'b1;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (count_q != '0) begin
          front_d = wrap_add(front_q, CNT_W'(1));
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      CMD_PEEK: ok_d = 1'b1;
      default:  ok_d = 1'b0;
    endcase
  end

  // Commit pointer and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q <= ok_d;
    end
  end

  // Storage: one write port, two registered read ports
  assign rear_idx = wrap_add(front_q, count_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_front_q <= mem[front_q];
      rd_rear_q  <= mem[rear_idx];
    end
  end

  // Drive the result fields
  assign accepted_o   = ok_q;
  assign is_empty_o   = (count_q == '0);
  assign is_full_o    = full_now;
  assign front_word_o = is_empty_o ? '1 : rd_front_q;
  assign rear_word_o  = is_empty_o ? '1 : rd_rear_q;

`ifndef ASSERT_OFF
  // Count never exceeds the storage depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  // A successful push grows the count by one
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && we) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not grow the count");

  // A refused command leaves pointer and count unchanged
  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !ok_d) |=> ($stable(count_q) && $stable(front_q)))
    else $error("refused command changed the state");
`endif

endmodule

/* hw/rtl/bounded_double_ended_queue_core.sv */
// Top level of the bounded deque: command channel, APB register and result strobe.
//
// Usage:
//   Command channel: drive cmd_i and push_value_i with start_i high; the
//   command transfers at a rising edge where start_i is high and busy_o low.
//   Result channel: done_o is high for exactly one cycle with accepted_o,
//   front_word_o, rear_word_o, is_empty_o and is_full_o valid; the result
//   transfers at the edge ending that cycle. The receiver cannot stall.
//   Sequence: after the command edge the core steps through execute, storage
//   read and result. busy_o covers the execute and read steps, so a new
//   command can transfer in the cycle that shows a result, but not before:
//   commands do not overlap, since the storage array is read in its own
//   registered step after its update.
//   Configuration: APB register 0 (byte address 0) holds queue_capacity,
//   5 bits, reset 16; values above 16 act as 16. Write only while idle.
//   Reset: asynchronous, active low; clears the deque to empty with the
//   front pointer at slot 0. Storage contents are not cleared; only
//   written slots ever reach the result words.
module bounded_double_ended_queue_core import bdq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic signed [WORD_W-1:0] push_value_i,
  // result channel
  output logic                     done_o,
  output logic                     accepted_o,
  output logic signed [WORD_W-1:0] front_word_o,
  output logic signed [WORD_W-1:0] rear_word_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  // APB configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready
);

  ctrl_cmd_t        ctrl_cmd;
  logic [CAP_W-1:0] capacity_q;
  logic             cfg_wr;

  // APB register: always ready, decode on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_W'(CAP_RESET);
    end else if (cfg_wr) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  bdq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (ctrl_cmd)
  );

  bdq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .op_i         (cmd_i),
    .push_value_i (push_value_i),
    .capacity_i   (capacity_q),
    .accepted_o   (accepted_o),
    .front_word_o (front_word_o),
    .rear_word_o  (rear_word_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

endmodule

/* tb/bounded_double_ended_queue_core_test.sv */
// Self-checking testbench for the bounded deque core: command, result and APB traffic.
module bounded_double_ended_queue_core_test;
  import bdq_pkg::*;

  localparam int unsigned PERIOD     = 10;
  localparam int unsigned RUN_LIMIT  = 3_000_000;
  localparam int unsigned SETTLE_CYC = 8;
  localparam int unsigned BLOCKS     = 15;
  localparam int unsigned BLOCK_LEN  = 50;

  // One result of the deque as seen on the result ports
  typedef struct packed {
    logic                     accepted;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     is_empty;
    logic                     is_full;
  } deque_result_t;

  // Shadow deque plus the queue of results still to arrive
  class deque_scoreboard;
    logic signed [WORD_W-1:0] slot_mem [DEPTH];
    int                       head_idx;
    int                       fill;
    int                       cap_reg;
    deque_result_t            pending_q [$];
    int                       errors;

    function new();
      head_idx = 0;
      fill     = 0;
      cap_reg  = CAP_RESET;
      errors   = 0;
      foreach (slot_mem[i]) slot_mem[i] = '0;
    endfunction

    function void set_capacity(int val);
      cap_reg = val;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Apply one transferred command to the shadow deque and queue its result
    function void note(logic [CMD_W-1:0] op, logic signed [WORD_W-1:0] word);
      deque_result_t res;
      int            limit;
      limit        = (cap_reg > int'(DEPTH)) ? int'(DEPTH) : cap_reg;
      res.accepted = 1'b0;
      case (op)
        CMD_PUSH_FRONT: begin
          if (fill < limit) begin
            head_idx = (head_idx == 0) ? int'(DEPTH) - 1 : head_idx - 1;
            slot_mem[head_idx] = word;
            fill++;
            res.accepted = 1'b1;
          end
        end
        CMD_PUSH_REAR: begin
          if (fill < limit) begin
            slot_mem[(head_idx + fill) % int'(DEPTH)] = word;
            fill++;
            res.accepted = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (fill > 0) begin
            head_idx = (head_idx + 1) % int'(DEPTH);
            fill--;
            res.accepted = 1'b1;
          end
        end
        CMD_POP_REAR: begin
          if (fill > 0) begin
            fill--;
            res.accepted = 1'b1;
          end
        end
        CMD_PEEK: begin
          res.accepted = 1'b1;
        end
        default: begin
          res.accepted = 1'b0;
        end
      endcase
      if (fill > 0) begin
        res.front_word = slot_mem[head_idx];
        res.rear_word  = slot_mem[(head_idx + fill - 1) % int'(DEPTH)];
      end else begin
        res.front_word = -1;
        res.rear_word  = -1;
      end
      res.is_empty = (fill == 0);
      res.is_full  = (fill >= limit);
      pending_q.push_back(res);
    endfunction

    // Compare one result transfer against the oldest expectation
    task check(deque_result_t got);
      deque_result_t want;
      if (pending_q.size() == 0) begin
        report("result with no command outstanding");
      end else begin
        want = pending_q.pop_front();
        if (got.accepted !== want.accepted)
          report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
        if (got.front_word !== want.front_word)
          report($sformatf("front_word got %0d want %0d", got.front_word, want.front_word));
        if (got.rear_word !== want.rear_word)
          report($sformatf("rear_word got %0d want %0d", got.rear_word, want.rear_word));
        if (got.is_empty !== want.is_empty)
          report($sformatf("is_empty got %0b want %0b", got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
          report($sformatf("is_full got %0b want %0b", got.is_full, want.is_full));
      end
    endtask

    task finish_check();
      if (pending_q.size() != 0)
        report($sformatf("%0d results never arrived", pending_q.size()));
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [CMD_W-1:0]         cmd_i;
  logic signed [WORD_W-1:0] push_value_i;
  logic                     done_o;
  logic                     accepted_o;
  logic signed [WORD_W-1:0] front_word_o;
  logic signed [WORD_W-1:0] rear_word_o;
  logic                     is_empty_o;
  logic                     is_full_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  deque_scoreboard sb;
  int              sender_idle_pct;

  bounded_double_ended_queue_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .push_value_i (push_value_i),
    .done_o       (done_o),
    .accepted_o   (accepted_o),
    .front_word_o (front_word_o),
    .rear_word_o  (rear_word_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Toggle the clock
  initial clk_i = 1'b0;
  always #(PERIOD / 2) clk_i = ~clk_i;

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check('{accepted_o, front_word_o, rear_word_o, is_empty_o, is_full_o});
    end
  end

  // Hold one command until it transfers, with an optional gap ahead of it
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] word);
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    start_i      = 1'b1;
    cmd_i        = op;
    push_value_i = word;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note(op, word);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every outstanding result has come back
  task automatic drain();
    start_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Write the capacity register through a setup and an access cycle
  task automatic write_capacity(input int val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_AW'(REG_CAPACITY) << 2;
    pwdata  = APB_DW'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_capacity(val & ((1 << CAP_W) - 1));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Favor corner words now and then
  function automatic logic signed [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return {1'b0, {(WORD_W - 1){1'b1}}};
    if (r < 6) return {1'b1, {(WORD_W - 1){1'b0}}};
    if (r < 8) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // Mostly pushes and pops, with some peeks and unknown codes
  function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return CMD_W'($urandom_range(7, 5));
    if (r < 12) return CMD_PEEK;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
    return $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
  endfunction

  // End the run if it hangs
  initial begin
    #(RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int cap_plan [BLOCKS];
    int cap_val;

    cap_plan = '{31, 1, 0, 17, 5, 16, 2, 31, 3, 0, 16, 8, 31, 1, 16};
    sb              = new();
    sender_idle_pct = 15;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = CMD_PEEK;
    push_value_i    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty deque at reset capacity: refused pops, peek and unknown codes
    send_cmd(CMD_PEEK, 32'sd5);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_W'(5), 32'sd1);
    send_cmd(CMD_W'(6), 32'sd2);
    send_cmd(CMD_W'(7), 32'sd3);
    // Extreme words at both ends, then unwind from both ends
    send_cmd(CMD_PUSH_REAR, {1'b0, {(WORD_W - 1){1'b1}}});
    send_cmd(CMD_PUSH_FRONT, {1'b1, {(WORD_W - 1){1'b0}}});
    send_cmd(CMD_PUSH_REAR, '0);
    send_cmd(CMD_PUSH_FRONT, -32'sd1);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_REAR, '0);
    drain();

    // Capacity of one: second push refused while full
    write_capacity(1);
    send_cmd(CMD_PUSH_FRONT, 32'sd123);
    send_cmd(CMD_PUSH_REAR, 32'sd456);
    send_cmd(CMD_POP_REAR, '0);
    drain();

    // Capacity of zero: empty and full together, every push refused
    write_capacity(0);
    send_cmd(CMD_PUSH_REAR, 32'sd77);
    send_cmd(CMD_PEEK, '0);
    drain();

    // Capacity lowered below the count: entries kept, pushes refused until pops bring the count below it
    write_capacity(16);
    send_cmd(CMD_PUSH_REAR, 32'sd10);
    send_cmd(CMD_PUSH_REAR, 32'sd20);
    send_cmd(CMD_PUSH_REAR, 32'sd30);
    drain();
    write_capacity(2);
    send_cmd(CMD_PUSH_FRONT, 32'sd40);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_PUSH_REAR, 32'sd50);
    send_cmd(CMD_POP_REAR, '0);
    send_cmd(CMD_PUSH_FRONT, 32'sd60);

    // Random blocks, each under its own capacity; fill first, then thin out
    for (int b = 0; b < BLOCKS; b++) begin
      drain();
      sender_idle_pct = (b < 5) ? 15 : ((b < 10) ? 60 : 0);
      cap_val = ((b % 4) == 3) ? $urandom_range(31) : cap_plan[b];
      write_capacity(cap_val);
      for (int k = 0; k < BLOCK_LEN; k++) begin
        send_cmd(pick_cmd((k < 35) ? 75 : 30), pick_word());
      end
    end

    // Wait out the last results, then judge
    drain();
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
